### rtl/rtpr_pkg.sv
// ----------------------------------------------------------------------------
// rtpr_pkg
// Shared types and constants for the RTP reorder buffer.
// ----------------------------------------------------------------------------
package rtpr_pkg;

  localparam int DEPTH_DEFAULT       = 64;
  localparam int HANDLE_BITS_DEFAULT = 8;

  localparam int SEQ_W    = 16;
  localparam int TIME_W   = 32;
  localparam int PT_W     = 7;
  localparam int HANDLE_W = 8;
  localparam int OCC_W    = 7;
  localparam int STAT_W   = 3;

  localparam logic [31:0] MAX_WAIT_RESET = 32'd500;

  // register index, taken from paddr[2]
  localparam logic REG_MAX_WAIT = 1'b0;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_PULL   = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_STORED   = 3'd0,
    ST_REPLACED = 3'd1,
    ST_WRONG_PT = 3'd2,
    ST_FULL     = 3'd3,
    ST_IN_ORDER = 3'd4,
    ST_SKIP     = 3'd5,
    ST_NONE     = 3'd6
  } status_t;

  // outcome of comparing one table entry against the current keys
  typedef struct packed {
    logic seq_hit;   // valid and sequence number equals the key
    logic take_min;  // valid and beats the running minimum
  } scan_cmp_t;

endpackage

### rtl/rtpr_in_if.sv
// ----------------------------------------------------------------------------
// rtpr_in_if
// Input channel: insert and pull transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rtpr_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] seq_no;
  logic [31:0] timestamp;
  logic [6:0]  payload_type;
  logic [7:0]  buffer_handle;
  logic [31:0] time_bound;
  logic [31:0] elapsed;

  modport source (
    output valid, kind, seq_no, timestamp, payload_type, buffer_handle,
           time_bound, elapsed,
    input  ready
  );

  modport sink (
    input  valid, kind, seq_no, timestamp, payload_type, buffer_handle,
           time_bound, elapsed,
    output ready
  );
endinterface

### rtl/rtpr_out_if.sv
// ----------------------------------------------------------------------------
// rtpr_out_if
// Result channel: one result transaction per input transaction.
// ----------------------------------------------------------------------------
interface rtpr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] out_seq;
  logic [31:0] out_timestamp;
  logic [7:0]  out_handle;
  logic [6:0]  occupancy;

  modport source (
    output valid, status, out_seq, out_timestamp, out_handle, occupancy,
    input  ready
  );

  modport sink (
    input  valid, status, out_seq, out_timestamp, out_handle, occupancy,
    output ready
  );
endinterface

### rtl/rtpr_table.sv
// ----------------------------------------------------------------------------
// rtpr_table
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rtpr_table #(
  parameter int DEPTH = rtpr_pkg::DEPTH_DEFAULT,
  parameter int WIDTH = 56,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/rtpr_scan_unit.sv
// ----------------------------------------------------------------------------
// rtpr_scan_unit
// Shared compare unit: checks one entry per cycle for a sequence match and
// for a new minimum timestamp.
// ----------------------------------------------------------------------------
module rtpr_scan_unit (
  input  logic                       ent_valid,
  input  logic [rtpr_pkg::SEQ_W-1:0]  ent_seq,
  input  logic [rtpr_pkg::TIME_W-1:0] ent_time,
  input  logic [rtpr_pkg::SEQ_W-1:0]  key_seq,
  input  logic [rtpr_pkg::TIME_W-1:0] lim,
  input  logic                       best_ok,
  input  logic [rtpr_pkg::SEQ_W-1:0]  best_seq,
  output rtpr_pkg::scan_cmp_t        cmp
);

  logic t_less;
  logic t_tie;

  assign t_less = ent_time < lim;
  // equal timestamp only wins once a candidate exists, on lower sequence
  assign t_tie  = best_ok && (ent_time == lim) && (ent_seq < best_seq);

  assign cmp.seq_hit  = ent_valid && (ent_seq == key_seq);
  assign cmp.take_min = ent_valid && (t_less || t_tie);

endmodule

### rtl/rtp_reorder_buffer_core.sv
// ----------------------------------------------------------------------------
// rtp_reorder_buffer_core
// Reorder table for RTP packets keyed by sequence number.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : insert (kind 0) or pull (kind 1) transactions, valid/ready.
//   out_ch : exactly one result transaction per input transaction.
//   cfg_*  : APB-style port, max_wait at byte address 0, pready tied high.
// Each transaction is worked by one sequencer that walks the whole table
// through a single memory read port and one compare unit, one entry a
// cycle. A new transaction is taken only after the previous one has left
// the finish step; an insert with a non-zero payload type skips the scan
// and goes straight to the finish step.
// The result sits in an output register; the next transaction may be taken
// while it waits. If the receiver stalls with a result still held, the
// following transaction finishes its scan and then waits, stalling in_ch.
// Reset (synchronous, rst_n low) empties the table, sets last delivered to
// zero, re-arms the first out-of-order delivery and loads max_wait with 500.
// Entry contents are not cleared; only the valid bits are.
// ----------------------------------------------------------------------------
module rtp_reorder_buffer_core #(
  parameter int DEPTH       = rtpr_pkg::DEPTH_DEFAULT,
  parameter int HANDLE_BITS = rtpr_pkg::HANDLE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  rtpr_in_if.sink     in_ch,
  rtpr_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int HW = (HANDLE_BITS < rtpr_pkg::HANDLE_W) ? HANDLE_BITS : rtpr_pkg::HANDLE_W;
  localparam int EW = rtpr_pkg::SEQ_W + rtpr_pkg::TIME_W + HW;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [31:0] max_wait_r;
  logic        cfg_wr;

  // persistent state
  logic [DEPTH-1:0] valid_r;
  logic [CW-1:0]    held_r, held_nxt;
  logic [15:0]      last_delivered_r;
  logic             first_pending_r;

  // captured transaction
  logic        kind_r;
  logic        wrong_pt_r;
  logic        skip_ok_r;
  logic [15:0] key_r;
  logic [31:0] ts_r;
  logic [HW-1:0] hd_r;

  // scan sequencing
  logic [AW-1:0] issue_r;
  logic          issuing_r;
  logic          dv_r;
  logic [AW-1:0] didx_r;

  // scan results
  logic          found_r;
  logic [AW-1:0] found_idx_r;
  logic [31:0]   found_time_r;
  logic [HW-1:0] found_hd_r;
  logic          free_ok_r;
  logic [AW-1:0] free_idx_r;
  logic          best_ok_r;
  logic [AW-1:0] best_idx_r;
  logic [15:0]   best_seq_r;
  logic [31:0]   lim_r;
  logic [HW-1:0] best_hd_r;

  // output register
  logic        out_valid_r;
  logic [2:0]  status_r;
  logic [15:0] oseq_r;
  logic [31:0] otime_r;
  logic [7:0]  ohd_r;
  logic [6:0]  occ_r;

  logic in_acc;
  logic out_free;
  logic fin_go;

  logic [EW-1:0] rd_data;
  logic [15:0]   ent_seq;
  logic [31:0]   ent_time;
  logic [HW-1:0] ent_hd;
  logic          ent_valid;
  rtpr_pkg::scan_cmp_t cmp;

  // finish decisions
  rtpr_pkg::status_t res_status;
  logic          res_del;
  logic [AW-1:0] res_del_idx;
  logic [15:0]   res_seq;
  logic [31:0]   res_time;
  logic [HW-1:0] res_hd;
  logic          res_wr;
  logic [AW-1:0] res_wr_idx;
  logic          res_set_valid;
  logic          res_skip;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign fin_go      = (state_r == S_FIN) && out_free;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == rtpr_pkg::REG_MAX_WAIT) ? max_wait_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_wait_r <= rtpr_pkg::MAX_WAIT_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == rtpr_pkg::REG_MAX_WAIT)) begin
      max_wait_r <= cfg_pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Table and compare unit
  // ---------------------------------------------------------------------------
  rtpr_table #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_table (
    .clk   (clk),
    .we    (fin_go && res_wr),
    .waddr (res_wr_idx),
    .wdata ({key_r, ts_r, hd_r}),
    .raddr (issue_r),
    .rdata (rd_data)
  );

  assign ent_seq   = rd_data[EW-1 -: 16];
  assign ent_time  = rd_data[HW +: 32];
  assign ent_hd    = rd_data[HW-1:0];
  assign ent_valid = valid_r[didx_r];

  rtpr_scan_unit u_scan (
    .ent_valid (ent_valid),
    .ent_seq   (ent_seq),
    .ent_time  (ent_time),
    .key_seq   (key_r),
    .lim       (lim_r),
    .best_ok   (best_ok_r),
    .best_seq  (best_seq_r),
    .cmp       (cmp)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.kind == rtpr_pkg::KIND_INSERT && in_ch.payload_type != 7'd0) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (dv_r && didx_r == LAST_IDX) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      issuing_r <= 1'b0;
      dv_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dv_r    <= (state_r == S_SCAN) && issuing_r;
      if (in_acc) begin
        issuing_r <= 1'b1;
      end else if (state_r == S_SCAN && issue_r == LAST_IDX) begin
        issuing_r <= 1'b0;
      end
    end
  end

  // address walk and capture of the transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      issue_r    <= '0;
      kind_r     <= in_ch.kind;
      wrong_pt_r <= (in_ch.payload_type != 7'd0);
      skip_ok_r  <= first_pending_r || (in_ch.elapsed > max_wait_r);
      key_r      <= (in_ch.kind == rtpr_pkg::KIND_PULL) ? last_delivered_r + 16'd1
                                                        : in_ch.seq_no;
      ts_r       <= in_ch.timestamp;
      hd_r       <= in_ch.buffer_handle[HW-1:0];
      lim_r      <= in_ch.time_bound;
      found_r    <= 1'b0;
      free_ok_r  <= 1'b0;
      best_ok_r  <= 1'b0;
    end else begin
      if (state_r == S_SCAN && issuing_r) begin
        issue_r <= issue_r + AW'(1);
      end
      didx_r <= issue_r;
      if (dv_r) begin
        if (cmp.seq_hit && !found_r) begin
          found_r      <= 1'b1;
          found_idx_r  <= didx_r;
          found_time_r <= ent_time;
          found_hd_r   <= ent_hd;
        end
        if (!ent_valid && !free_ok_r) begin
          free_ok_r  <= 1'b1;
          free_idx_r <= didx_r;
        end
        if (cmp.take_min) begin
          best_ok_r  <= 1'b1;
          best_idx_r <= didx_r;
          best_seq_r <= ent_seq;
          lim_r      <= ent_time;
          best_hd_r  <= ent_hd;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Finish step: decide the result and the table update
  // ---------------------------------------------------------------------------
  always_comb begin
    res_status    = rtpr_pkg::ST_NONE;
    res_del       = 1'b0;
    res_del_idx   = found_idx_r;
    res_seq       = 16'd0;
    res_time      = 32'd0;
    res_hd        = '0;
    res_wr        = 1'b0;
    res_wr_idx    = found_idx_r;
    res_set_valid = 1'b0;
    res_skip      = 1'b0;
    if (kind_r == rtpr_pkg::KIND_INSERT) begin
      if (wrong_pt_r) begin
        res_status = rtpr_pkg::ST_WRONG_PT;
      end else if (found_r) begin
        res_status = rtpr_pkg::ST_REPLACED;
        res_wr     = 1'b1;
      end else if (free_ok_r) begin
        res_status    = rtpr_pkg::ST_STORED;
        res_wr        = 1'b1;
        res_wr_idx    = free_idx_r;
        res_set_valid = 1'b1;
      end else begin
        res_status = rtpr_pkg::ST_FULL;
      end
    end else begin
      if (found_r) begin
        res_status = rtpr_pkg::ST_IN_ORDER;
        res_del    = 1'b1;
        res_seq    = key_r;
        res_time   = found_time_r;
        res_hd     = found_hd_r;
      end else if (skip_ok_r && best_ok_r) begin
        res_status  = rtpr_pkg::ST_SKIP;
        res_del     = 1'b1;
        res_del_idx = best_idx_r;
        res_seq     = best_seq_r;
        res_time    = lim_r;
        res_hd      = best_hd_r;
        res_skip    = 1'b1;
      end
    end
  end

  always_comb begin
    held_nxt = held_r;
    if (res_set_valid) begin
      held_nxt = held_r + CW'(1);
    end else if (res_del) begin
      held_nxt = held_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r          <= '0;
      held_r           <= '0;
      last_delivered_r <= 16'd0;
      first_pending_r  <= 1'b1;
    end else if (fin_go) begin
      held_r <= held_nxt;
      if (res_set_valid) begin
        valid_r[res_wr_idx] <= 1'b1;
      end
      if (res_del) begin
        valid_r[res_del_idx] <= 1'b0;
        last_delivered_r     <= res_seq;
      end
      if (res_skip) begin
        first_pending_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      status_r <= res_status;
      oseq_r   <= res_seq;
      otime_r  <= res_time;
      ohd_r    <= 8'(res_hd);
      occ_r    <= 7'(held_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.out_seq       = oseq_r;
  assign out_ch.out_timestamp = otime_r;
  assign out_ch.out_handle    = ohd_r;
  assign out_ch.occupancy     = occ_r;

`ifndef SYNTH
  // entry count tracks the valid bits
  a_held_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    held_r == CW'($countones(valid_r)))
    else $error("held count differs from number of valid entries");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(DEPTH))
    else $error("held count beyond table depth");

  // one transaction at a time in the sequencer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input accepted while a transaction is in progress");

  // a skip delivery clears the first-pending flag
  a_skip_clears_first: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && res_skip) |=> !first_pending_r)
    else $error("first pending flag still set after skip delivery");
`endif

endmodule

### tb/sv/tb_rtp_reorder_buffer_core.sv
// ----------------------------------------------------------------------------
// tb_rtp_reorder_buffer_core
// Self-checking bench for the RTP reorder buffer core. A directed table
// covers reset state, field extremes, replacement, wrong payload type,
// in-order and skip delivery, sequence wrap and timestamp ties. Random
// episodes then follow: shuffled packet streams with pulls, table fills,
// duplicates and noise. They run under several max_wait settings and are
// checked against a behavioural predictor of the table.
// ----------------------------------------------------------------------------
module tb_rtp_reorder_buffer_core;

  localparam int DEPTH       = rtpr_pkg::DEPTH_DEFAULT;
  localparam int HANDLE_BITS = rtpr_pkg::HANDLE_BITS_DEFAULT;
  localparam int SEQ_W       = rtpr_pkg::SEQ_W;
  localparam int TIME_W      = rtpr_pkg::TIME_W;
  localparam int PT_W        = rtpr_pkg::PT_W;
  localparam int HANDLE_W    = rtpr_pkg::HANDLE_W;
  localparam int OCC_W       = rtpr_pkg::OCC_W;
  localparam logic [HANDLE_W-1:0] HANDLE_MASK = HANDLE_W'((64'd1 << HANDLE_BITS) - 1);
  localparam logic [2:0] MAX_WAIT_ADDR = {rtpr_pkg::REG_MAX_WAIT, 2'b00};
  localparam int N_DIR           = 21;
  localparam int N_PHASES        = 5;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int EXP_SLOTS       = 16;
  localparam int MAX_STREAM      = 16;

  typedef struct packed {
    logic                kind;
    logic [SEQ_W-1:0]    seq;
    logic [TIME_W-1:0]   ts;
    logic [PT_W-1:0]     pt;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   bound;
    logic [TIME_W-1:0]   elapsed;
  } pkt_item_t;

  typedef struct packed {
    rtpr_pkg::status_t   status;
    logic [SEQ_W-1:0]    seq;
    logic [TIME_W-1:0]   ts;
    logic [HANDLE_W-1:0] handle;
    logic [OCC_W-1:0]    occ;
  } pkt_result_t;

  typedef struct packed {
    pkt_item_t   item;
    logic        typed;
    pkt_result_t res;
  } dir_row_t;

  localparam pkt_result_t NO_RESULT = '0;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rtpr_in_if  in_ch ();
  rtpr_out_if out_ch ();

  rtp_reorder_buffer_core #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predicted table state
  bit                  slot_used   [DEPTH];
  logic [SEQ_W-1:0]    slot_seq    [DEPTH];
  logic [TIME_W-1:0]   slot_ts     [DEPTH];
  logic [HANDLE_W-1:0] slot_handle [DEPTH];
  logic [SEQ_W-1:0]    last_seq;
  bit                  skip_armed;
  int                  held_cnt;
  logic [31:0]         wait_limit;

  // expected results, in acceptance order
  pkt_result_t exp_fifo [EXP_SLOTS];
  int          exp_wr_cnt;
  int          exp_rd_cnt;
  dir_row_t    dir_rows [N_DIR];
  logic [31:0] wait_settings [N_PHASES];
  int          stat_seen [8];
  int          err_cnt;
  int          sent_cnt;
  int          useful_cnt;
  int          checked_cnt;
  int          burst_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic pkt_item_t ins(input logic [SEQ_W-1:0] s, input logic [TIME_W-1:0] t,
                                    input logic [PT_W-1:0] p, input logic [HANDLE_W-1:0] h);
    pkt_item_t it;
    it.kind    = rtpr_pkg::KIND_INSERT;
    it.seq     = s;
    it.ts      = t;
    it.pt      = p;
    it.handle  = h;
    it.bound   = $urandom;
    it.elapsed = $urandom;
    return it;
  endfunction

  function automatic pkt_item_t pull(input logic [TIME_W-1:0] b, input logic [TIME_W-1:0] e);
    pkt_item_t it;
    it.kind    = rtpr_pkg::KIND_PULL;
    it.seq     = SEQ_W'($urandom);
    it.ts      = $urandom;
    it.pt      = PT_W'($urandom);
    it.handle  = HANDLE_W'($urandom);
    it.bound   = b;
    it.elapsed = e;
    return it;
  endfunction

  function automatic void take_slot(input int idx, input rtpr_pkg::status_t st,
                                    inout pkt_result_t r);
    r.status        = st;
    r.seq           = slot_seq[idx];
    r.ts            = slot_ts[idx];
    r.handle        = slot_handle[idx];
    slot_used[idx]  = 1'b0;
    last_seq        = slot_seq[idx];
    held_cnt--;
  endfunction

  function automatic void reorder_predict(input pkt_item_t it, output pkt_result_t r);
    int               hit;
    int               free_slot;
    int               best;
    logic [SEQ_W-1:0] want_seq;
    logic [TIME_W-1:0] lim;
    r         = NO_RESULT;
    r.status  = rtpr_pkg::ST_NONE;
    hit       = -1;
    free_slot = -1;
    best      = -1;
    if (it.kind == rtpr_pkg::KIND_INSERT) begin
      if (it.pt != '0) begin
        r.status = rtpr_pkg::ST_WRONG_PT;
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_used[i] && slot_seq[i] == it.seq && hit < 0) hit = i;
          if (!slot_used[i] && free_slot < 0) free_slot = i;
        end
        if (hit >= 0) begin
          slot_ts[hit]     = it.ts;
          slot_handle[hit] = it.handle & HANDLE_MASK;
          r.status         = rtpr_pkg::ST_REPLACED;
        end else if (free_slot >= 0) begin
          slot_used[free_slot]   = 1'b1;
          slot_seq[free_slot]    = it.seq;
          slot_ts[free_slot]     = it.ts;
          slot_handle[free_slot] = it.handle & HANDLE_MASK;
          held_cnt++;
          r.status = rtpr_pkg::ST_STORED;
        end else begin
          r.status = rtpr_pkg::ST_FULL;
        end
      end
    end else begin
      want_seq = last_seq + 16'd1;
      for (int i = 0; i < DEPTH; i++)
        if (slot_used[i] && slot_seq[i] == want_seq && hit < 0) hit = i;
      if (hit >= 0) begin
        take_slot(hit, rtpr_pkg::ST_IN_ORDER, r);
      end else if (skip_armed || it.elapsed > wait_limit) begin
        // oldest timestamp under the bound, ties to the lower sequence number
        lim = it.bound;
        for (int i = 0; i < DEPTH; i++) begin
          if (!slot_used[i]) continue;
          if (slot_ts[i] < lim) begin
            lim  = slot_ts[i];
            best = i;
          end else if (best >= 0 && slot_ts[i] == lim && slot_seq[i] < slot_seq[best]) begin
            best = i;
          end
        end
        if (best >= 0) begin
          skip_armed = 1'b0;
          take_slot(best, rtpr_pkg::ST_SKIP, r);
        end
      end
    end
    r.occ = OCC_W'(held_cnt);
  endfunction

  function automatic logic [TIME_W-1:0] pick_bound();
    int idx;
    idx = $urandom_range(0, DEPTH - 1);
    case ($urandom_range(0, 4))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'd0;
      2:       return slot_used[idx] ? slot_ts[idx] + 32'($urandom_range(0, 1)) : $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_elapsed();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return wait_limit;
      2:       return wait_limit + 32'd1;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic offer(input pkt_item_t it, input logic typed, input pkt_result_t typed_res);
    pkt_result_t r;
    int          gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 150);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= it.kind;
    in_ch.seq_no        <= it.seq;
    in_ch.timestamp     <= it.ts;
    in_ch.payload_type  <= it.pt;
    in_ch.buffer_handle <= it.handle;
    in_ch.time_bound    <= it.bound;
    in_ch.elapsed       <= it.elapsed;
    do @(posedge clk); while (!in_ch.ready);
    reorder_predict(it, r);
    exp_fifo[exp_wr_cnt % EXP_SLOTS] = typed ? typed_res : r;
    exp_wr_cnt++;
    sent_cnt++;
    if (it.kind == rtpr_pkg::KIND_PULL || it.pt == '0) useful_cnt++;
  endtask

  // hold the sender off until the block has nothing left in flight
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (exp_wr_cnt != exp_rd_cnt) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == MAX_WAIT_ADDR) wait_limit = val;
  endtask

  task automatic run_episode();
    int               sel;
    int               n;
    int               lost;
    int               step;
    int               j;
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] tmp;
    logic [TIME_W-1:0] ts0;
    logic [SEQ_W-1:0] order [MAX_STREAM];
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      // packet stream around the next expected sequence, arriving shuffled
      n    = $urandom_range(2, 12);
      base = ($urandom_range(0, 3) == 0) ? last_seq + 16'($urandom_range(2, 6))
                                         : last_seq + 16'd1;
      ts0  = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 : $urandom;
      step = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) order[i] = base + 16'(i);
      for (int i = n - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      lost = $urandom_range(0, 2 * n);
      for (int i = 0; i < n; i++) begin
        if (i != lost)
          offer(ins(order[i], ts0 + 32'(step) * 32'(order[i] - base), '0,
                    HANDLE_W'($urandom)), 1'b0, NO_RESULT);
        if ($urandom_range(0, 3) == 0)
          offer(pull(pick_bound(), pick_elapsed()), 1'b0, NO_RESULT);
      end
      repeat (n + 2) offer(pull(pick_bound(), pick_elapsed()), 1'b0, NO_RESULT);
    end else if (sel < 7) begin
      // overfill the table, then drain it
      n = DEPTH + $urandom_range(1, 6);
      case ($urandom_range(0, 7))
        0, 1, 2, 3: base = last_seq + 16'd1;
        4:          base = 16'hFFE0;
        default:    base = SEQ_W'($urandom);
      endcase
      for (int i = 0; i < n; i++)
        offer(ins(base + 16'(i), 32'($urandom_range(0, 15)), '0, HANDLE_W'($urandom)),
              1'b0, NO_RESULT);
      repeat ($urandom_range(DEPTH / 2, DEPTH + 4))
        offer(pull(($urandom_range(0, 3) == 0) ? pick_bound() : 32'hFFFF_FFFF,
                   ($urandom_range(0, 3) == 0) ? pick_elapsed() : 32'hFFFF_FFFF),
              1'b0, NO_RESULT);
    end else if (sel == 7) begin
      base = ($urandom_range(0, 1) == 0) ? last_seq + 16'd1 : SEQ_W'($urandom);
      repeat ($urandom_range(2, 5))
        offer(ins(base, $urandom, '0, HANDLE_W'($urandom)), 1'b0, NO_RESULT);
      offer(pull(pick_bound(), pick_elapsed()), 1'b0, NO_RESULT);
    end else begin
      repeat ($urandom_range(3, 10)) begin
        if ($urandom_range(0, 1) == 0)
          offer(ins(SEQ_W'($urandom), $urandom,
                    ($urandom_range(0, 1) == 0) ? PT_W'(0) : PT_W'($urandom),
                    HANDLE_W'($urandom)), 1'b0, NO_RESULT);
        else
          offer(pull($urandom, $urandom), 1'b0, NO_RESULT);
      end
    end
  endtask

  // receiver: ready runs of random length broken by short and long stalls
  initial begin : rx_pattern
    int run_len;
    int stall_len;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      run_len = $urandom_range(1, 200);
      out_ch.ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      case ($urandom_range(0, 3))
        0:       stall_len = 0;
        1:       stall_len = $urandom_range(1, 8);
        default: stall_len = $urandom_range(20, 160);
      endcase
      if (stall_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  task automatic flag_field(input string name, input logic [31:0] exp_v,
                            input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    pkt_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      checked_cnt++;
      if (!$isunknown(out_ch.status)) stat_seen[out_ch.status]++;
      if (exp_wr_cnt == exp_rd_cnt) begin
        $display("%0t: result with nothing outstanding, expected none, actual status %0d",
                 $time, out_ch.status);
        err_cnt++;
      end else begin
        want = exp_fifo[exp_rd_cnt % EXP_SLOTS];
        exp_rd_cnt++;
        flag_field("status", 32'(want.status), 32'(out_ch.status));
        flag_field("out_seq", 32'(want.seq), 32'(out_ch.out_seq));
        flag_field("out_timestamp", want.ts, out_ch.out_timestamp);
        flag_field("out_handle", 32'(want.handle), 32'(out_ch.out_handle));
        flag_field("occupancy", 32'(want.occ), 32'(out_ch.occupancy));
      end
    end
  end

  initial begin : stimulus
    int target;
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= rtpr_pkg::KIND_INSERT;
    in_ch.seq_no        <= '0;
    in_ch.timestamp     <= '0;
    in_ch.payload_type  <= '0;
    in_ch.buffer_handle <= '0;
    in_ch.time_bound    <= '0;
    in_ch.elapsed       <= '0;
    cfg_psel            <= 1'b0;
    cfg_penable         <= 1'b0;
    cfg_pwrite          <= 1'b0;
    cfg_paddr           <= '0;
    cfg_pwdata          <= '0;
    rst_n               <= 1'b0;
    for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
    last_seq    = '0;
    skip_armed  = 1'b1;
    held_cnt    = 0;
    wait_limit  = rtpr_pkg::MAX_WAIT_RESET;
    exp_wr_cnt  = 0;
    exp_rd_cnt  = 0;
    err_cnt     = 0;
    sent_cnt    = 0;
    useful_cnt  = 0;
    checked_cnt = 0;
    burst_left  = 0;
    foreach (stat_seen[i]) stat_seen[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows = '{
      '{pull(32'hFFFF_FFFF, 32'd0), 1'b1,
        '{rtpr_pkg::ST_NONE, 16'h0, 32'h0, 8'h00, 7'd0}},
      '{ins(16'hFFFF, 32'hFFFF_FFFF, 7'd0, 8'hFF), 1'b1,
        '{rtpr_pkg::ST_STORED, 16'h0, 32'h0, 8'h00, 7'd1}},
      '{ins(16'h0005, 32'd100, 7'h7F, 8'h00), 1'b1,
        '{rtpr_pkg::ST_WRONG_PT, 16'h0, 32'h0, 8'h00, 7'd1}},
      '{ins(16'h0005, 32'd100, 7'h01, 8'h00), 1'b1,
        '{rtpr_pkg::ST_WRONG_PT, 16'h0, 32'h0, 8'h00, 7'd1}},
      '{ins(16'h0000, 32'd0, 7'd0, 8'h00), 1'b1,
        '{rtpr_pkg::ST_STORED, 16'h0, 32'h0, 8'h00, 7'd2}},
      '{ins(16'hFFFF, 32'd7, 7'd0, 8'hAA), 1'b1,
        '{rtpr_pkg::ST_REPLACED, 16'h0, 32'h0, 8'h00, 7'd2}},
      '{ins(16'h0001, 32'd50, 7'd0, 8'h11), 1'b1,
        '{rtpr_pkg::ST_STORED, 16'h0, 32'h0, 8'h00, 7'd3}},
      '{pull(32'd0, 32'hFFFF_FFFF), 1'b1,
        '{rtpr_pkg::ST_IN_ORDER, 16'h1, 32'd50, 8'h11, 7'd2}},
      '{pull(32'd0, 32'd0), 1'b1,
        '{rtpr_pkg::ST_NONE, 16'h0, 32'h0, 8'h00, 7'd2}},
      '{pull(32'd8, 32'd0), 1'b1,
        '{rtpr_pkg::ST_SKIP, 16'h0, 32'h0, 8'h00, 7'd1}},
      '{pull(32'hFFFF_FFFF, 32'd500), 1'b1,
        '{rtpr_pkg::ST_NONE, 16'h0, 32'h0, 8'h00, 7'd1}},
      '{pull(32'hFFFF_FFFF, 32'd501), 1'b1,
        '{rtpr_pkg::ST_SKIP, 16'hFFFF, 32'd7, 8'hAA, 7'd0}},
      '{ins(16'h0000, 32'd3, 7'd0, 8'h55), 1'b1,
        '{rtpr_pkg::ST_STORED, 16'h0, 32'h0, 8'h00, 7'd1}},
      // last delivered was 0xFFFF, so the wanted sequence wraps to zero
      '{pull(32'd0, 32'd0), 1'b1,
        '{rtpr_pkg::ST_IN_ORDER, 16'h0, 32'd3, 8'h55, 7'd0}},
      '{ins(16'd40, 32'd20, 7'd0, 8'h01), 1'b0, NO_RESULT},
      '{ins(16'd30, 32'd20, 7'd0, 8'h02), 1'b0, NO_RESULT},
      '{ins(16'd35, 32'd25, 7'd0, 8'h03), 1'b0, NO_RESULT},
      '{pull(32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, NO_RESULT},
      '{pull(32'd21, 32'd1000), 1'b0, NO_RESULT},
      '{pull(32'd0, 32'd0), 1'b0, NO_RESULT},
      '{ins(16'h8000, 32'h8000_0000, 7'h40, 8'h80), 1'b1,
        '{rtpr_pkg::ST_WRONG_PT, 16'h0, 32'h0, 8'h00, 7'd1}}
    };
    foreach (dir_rows[i]) offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    wait_settings = '{32'd0, 32'hFFFF_FFFF, 32'($urandom_range(1, 2000)),
                      rtpr_pkg::MAX_WAIT_RESET, $urandom};
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      write_reg(MAX_WAIT_ADDR, wait_settings[ph]);
      target = useful_cnt + ITEMS_PER_PHASE;
      while (useful_cnt < target) run_episode();
    end
    drain();

    $display("Sent %0d transactions (%0d directed) under %0d max_wait settings, %0d results seen",
             sent_cnt, N_DIR, N_PHASES, checked_cnt);
    $display("Mix: stored %0d replaced %0d wrong-type %0d full %0d in-order %0d skip %0d none %0d",
             stat_seen[rtpr_pkg::ST_STORED], stat_seen[rtpr_pkg::ST_REPLACED],
             stat_seen[rtpr_pkg::ST_WRONG_PT], stat_seen[rtpr_pkg::ST_FULL],
             stat_seen[rtpr_pkg::ST_IN_ORDER], stat_seen[rtpr_pkg::ST_SKIP],
             stat_seen[rtpr_pkg::ST_NONE]);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
